/* hdl/hfc_pkg.sv */
// Shared types and constants for the half/single precision converter pipeline.
package hfc_pkg;

    // Direction codes carried on tuser.
    localparam logic OP_H2F = 1'b0;
    localparam logic OP_F2H = 1'b1;

    // Exponent bias difference between binary32 and binary16.
    localparam logic [7:0] BIAS_DIFF    = 8'd112;
    // Float exponent fields below this give a signed zero half.
    localparam logic [7:0] F_TINY_LIM   = 8'd102;
    // Float exponent fields up to this give a subnormal half.
    localparam logic [7:0] F_SUB_LIM    = 8'd112;
    // Largest float exponent field that still fits a finite half.
    localparam logic [7:0] F_MAX_FIN    = 8'd142;
    localparam logic [7:0] F_EXP_ONES   = 8'hff;
    localparam logic [4:0] H_EXP_ONES   = 5'h1f;
    // Exponent of a normalized subnormal half is this minus the leading-zero count.
    localparam logic [7:0] H_SUB_EXP    = 8'd118;
    // Subnormal float-to-half shift is this minus the exponent field.
    localparam logic [7:0] F_SUB_SHBASE = 8'd113;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_SUB,
        CLS_SPEC,
        CLS_OVF,
        CLS_CARRY,
        CLS_NORM
    } cls_t;

    // Item as it moves between the pipeline stages.
    typedef struct packed {
        logic        op;
        logic        sign;
        cls_t        cls;
        logic [7:0]  expf;
        logic [3:0]  shamt;
        logic [23:0] mant;
    } item_t;

endpackage

/* hdl/half_float_converter_top.sv */
// Top level of the binary16/binary32 bit-pattern converter.
// The converter takes one operand per cycle and returns each result through three
// register stages: decode and rounding, the normalizing shifter, and exponent
// assembly. Each stage holds its item while the output is stalled and still takes a
// new one whenever the stage ahead moves, so throughput stays at one transfer per
// cycle as long as m_tready is high.
// tuser selects the direction: 0 widens the half in tdata[15:0] to a float, 1
// narrows a float to a half returned in the low 16 bits with the upper bits zero.
module half_float_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] result
);

    logic           dec_valid;
    logic           dec_ready;
    hfc_pkg::item_t dec_item;
    logic           sh_valid;
    logic           sh_ready;
    hfc_pkg::item_t sh_item;

    hfc_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_operand (s_tdata),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .out_item   (dec_item)
    );

    hfc_shift u_shift (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_item   (dec_item),
        .out_valid (sh_valid),
        .out_ready (sh_ready),
        .out_item  (sh_item)
    );

    hfc_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (sh_valid),
        .in_ready   (sh_ready),
        .in_item    (sh_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_tdata)
    );

endmodule

/* hdl/hfc_decode.sv */
// First stage: classify the operand, round the float mantissa and count leading zeros.
module hfc_decode (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_op,
    input  logic [31:0]    in_operand,
    output logic           out_valid,
    input  logic           out_ready,
    output hfc_pkg::item_t out_item
);

    logic           valid_reg;
    logic           valid_next;
    hfc_pkg::item_t item_reg;
    hfc_pkg::item_t item_next;

    logic [4:0]  h_ex;
    logic [9:0]  h_man;
    logic [3:0]  h_lz;
    logic [7:0]  f_exp;
    logic [22:0] f_man;
    logic [23:0] f_mr;
    logic [9:0]  f_top;
    logic [7:0]  f_sh;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        h_ex  = in_operand[14:10];
        h_man = in_operand[9:0];
        h_lz  = 4'd15;
        for (int i = 0; i < 10; i++) begin
            if (h_man[i]) begin
                h_lz = 4'(15 - i);
            end
        end

        f_exp = in_operand[30:23];
        f_man = in_operand[22:0];
        // Round half up by adding mantissa bit 12 at bit 13.
        f_mr  = {1'b0, f_man} + {10'b0, f_man[12], 13'b0};
        f_sh  = hfc_pkg::F_SUB_SHBASE - f_exp;
        if (f_man == 23'd0) begin
            f_top = 10'd0;
        end else if (f_man[22:13] == 10'd0) begin
            f_top = 10'd1;
        end else begin
            f_top = f_man[22:13];
        end

        item_next.op    = in_op;
        item_next.expf  = 8'd0;
        item_next.shamt = 4'd0;
        item_next.mant  = 24'd0;
        item_next.cls   = hfc_pkg::CLS_NORM;
        if (in_op == hfc_pkg::OP_H2F) begin
            item_next.sign  = in_operand[15];
            item_next.expf  = {3'b0, h_ex};
            item_next.mant  = {14'b0, h_man};
            item_next.shamt = h_lz;
            if (h_ex == 5'd0 && h_man == 10'd0) begin
                item_next.cls = hfc_pkg::CLS_ZERO;
            end else if (h_ex == 5'd0) begin
                item_next.cls = hfc_pkg::CLS_SUB;
            end else if (h_ex == hfc_pkg::H_EXP_ONES) begin
                item_next.cls = hfc_pkg::CLS_SPEC;
            end else begin
                item_next.cls = hfc_pkg::CLS_NORM;
            end
        end else begin
            item_next.sign  = in_operand[31];
            item_next.expf  = f_exp;
            item_next.mant  = f_mr;
            item_next.shamt = f_sh[3:0];
            if (f_exp < hfc_pkg::F_TINY_LIM) begin
                item_next.cls = hfc_pkg::CLS_ZERO;
            end else if (f_exp <= hfc_pkg::F_SUB_LIM) begin
                item_next.cls = hfc_pkg::CLS_SUB;
            end else if (f_exp == hfc_pkg::F_EXP_ONES) begin
                // NaN keeps its payload ahead of the overflow check.
                item_next.cls  = hfc_pkg::CLS_SPEC;
                item_next.mant = {14'b0, f_top};
            end else if (f_exp > hfc_pkg::F_MAX_FIN) begin
                item_next.cls = hfc_pkg::CLS_OVF;
            end else if (f_mr[23]) begin
                item_next.cls = hfc_pkg::CLS_CARRY;
            end else begin
                item_next.cls = hfc_pkg::CLS_NORM;
            end
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* hdl/hfc_shift.sv */
// Second stage: normalize subnormal halves and denormalize small floats.
module hfc_shift (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hfc_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output hfc_pkg::item_t out_item
);

    logic           valid_reg;
    logic           valid_next;
    hfc_pkg::item_t item_reg;
    hfc_pkg::item_t item_next;

    logic [4:0]  up_amt;
    logic [23:0] up_val;
    logic [23:0] dn_val;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // The leading one of a subnormal half lands on bit 23 and is dropped later.
        up_amt = {1'b0, in_item.shamt} + 5'd8;
        up_val = {14'b0, in_item.mant[9:0]} << up_amt;
        dn_val = {1'b1, in_item.mant[22:0]} >> in_item.shamt;

        item_next = in_item;
        if (in_item.cls == hfc_pkg::CLS_SUB) begin
            if (in_item.op == hfc_pkg::OP_H2F) begin
                item_next.mant = up_val;
            end else begin
                item_next.mant = {14'b0, dn_val[22:13]};
            end
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* hdl/hfc_pack.sv */
// Third stage: compute the result exponent and assemble the output bit pattern.
module hfc_pack (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hfc_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_result
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    logic [7:0] f_exp_norm;
    logic [7:0] f_exp_sub;
    logic [7:0] h_exp_norm;
    logic [7:0] h_exp_carry;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        f_exp_norm  = {3'b0, in_item.expf[4:0]} + hfc_pkg::BIAS_DIFF;
        f_exp_sub   = hfc_pkg::H_SUB_EXP - {4'b0, in_item.shamt};
        h_exp_norm  = in_item.expf - hfc_pkg::BIAS_DIFF;
        h_exp_carry = in_item.expf - (hfc_pkg::BIAS_DIFF - 8'd1);

        result_next = 32'd0;
        if (in_item.op == hfc_pkg::OP_H2F) begin
            case (in_item.cls)
                hfc_pkg::CLS_ZERO: begin
                    result_next = {in_item.sign, 31'b0};
                end
                hfc_pkg::CLS_SUB: begin
                    result_next = {in_item.sign, f_exp_sub, in_item.mant[22:0]};
                end
                hfc_pkg::CLS_SPEC: begin
                    result_next = {in_item.sign, hfc_pkg::F_EXP_ONES,
                                   in_item.mant[9:0], 13'b0};
                end
                default: begin
                    result_next = {in_item.sign, f_exp_norm, in_item.mant[9:0], 13'b0};
                end
            endcase
        end else begin
            case (in_item.cls)
                hfc_pkg::CLS_ZERO: begin
                    result_next = {16'b0, in_item.sign, 15'b0};
                end
                hfc_pkg::CLS_SUB: begin
                    result_next = {16'b0, in_item.sign, 5'b0, in_item.mant[9:0]};
                end
                hfc_pkg::CLS_SPEC: begin
                    result_next = {16'b0, in_item.sign, hfc_pkg::H_EXP_ONES,
                                   in_item.mant[9:0]};
                end
                hfc_pkg::CLS_OVF: begin
                    result_next = {16'b0, in_item.sign, hfc_pkg::H_EXP_ONES, 10'b0};
                end
                hfc_pkg::CLS_CARRY: begin
                    result_next = {16'b0, in_item.sign, h_exp_carry[4:0], 10'b0};
                end
                default: begin
                    result_next = {16'b0, in_item.sign, h_exp_norm[4:0],
                                   in_item.mant[22:13]};
                end
            endcase
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the binary16/binary32 bit-pattern converter.
module tb_top;

    localparam int    HOLD_CYCLES = 60;
    localparam int    DRAIN_LIMIT = 2000;
    localparam int    PRINT_LIMIT = 20;

    typedef struct {
        logic        op;
        logic [31:0] operand;
        logic [31:0] result;
    } conv_check_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] operand
    logic        s_tuser  = hfc_pkg::OP_H2F; // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] result

    conv_check_t pending_results[$];
    conv_check_t oldest;
    int          err_count   = 0;
    int          h2f_sent    = 0;
    int          f2h_sent    = 0;
    int          results_ok  = 0;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    int          hold_reqs   = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;

    half_float_converter_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Widening: subnormal halves are normalized by the position of their top set bit.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  hexp;
        logic [9:0]  hman;
        logic [7:0]  fexp;
        logic [31:0] shifted;
        logic [22:0] fman;
        int          lz;
        int          i;
        hexp = h[14:10];
        hman = h[9:0];
        fexp = '0;
        fman = '0;
        if (hexp == 5'd0 && hman != 10'd0) begin
            lz = 16;
            for (i = 0; i < 10; i++) begin
                if (hman[i]) lz = 15 - i;
            end
            shifted = {22'd0, hman} << (lz + 8);
            fman = shifted[22:0];
            fexp = 8'(118 - lz);
        end else if (hexp == 5'h1f) begin
            fexp = 8'hff;
            fman = {hman, 13'd0};
        end else if (hexp != 5'd0) begin
            fexp = 8'(hexp) + 8'd112;
            fman = {hman, 13'd0};
        end
        return {h[15], fexp, fman};
    endfunction

    // Narrowing: round by adding mantissa bit 12 at bit 13, NaN wins over overflow.
    function automatic logic [15:0] single_to_half(input logic [31:0] f);
        int          e;
        logic [23:0] mr;
        logic [23:0] md;
        logic [9:0]  top;
        logic        sgn;
        sgn = f[31];
        e   = int'(f[30:23]) - 112;
        mr  = {1'b0, f[22:0]} + (f[12] ? 24'h002000 : 24'h000000);
        if (e < -10)
            return {sgn, 15'd0};
        if (e < 1) begin
            md = (mr | 24'h800000) >> (1 - e);
            return {sgn, 5'd0, md[22:13]};
        end
        if (f[30:23] == 8'hff) begin
            if (f[22:0] == 23'd0)
                return {sgn, 5'h1f, 10'd0};
            top = f[22:13];
            if (top == 10'd0) top = 10'd1;
            return {sgn, 5'h1f, top};
        end
        if (e > 30)
            return {sgn, 5'h1f, 10'd0};
        if (mr[23])
            return {sgn, 5'(e + 1), 10'd0};
        return {sgn, 5'(e), mr[22:13]};
    endfunction

    function automatic logic [31:0] convert_pattern(input logic op, input logic [31:0] operand);
        if (op == hfc_pkg::OP_H2F)
            return half_to_single(operand[15:0]);
        return {16'd0, single_to_half(operand)};
    endfunction

    function automatic logic [31:0] rand_operand(input logic op);
        logic [31:0] v;
        logic [7:0]  fexp;
        logic [4:0]  hexp;
        v = $urandom;
        if ($urandom_range(3) == 0)
            return v;
        if (op == hfc_pkg::OP_F2H) begin
            case ($urandom_range(9))
                0:       fexp = 8'h00;
                1:       fexp = 8'hff;
                2, 3, 4, 5: fexp = 8'($urandom_range(146, 98));
                default: fexp = 8'($urandom_range(255));
            endcase
            v[30:23] = fexp;
            case ($urandom_range(5))
                0: v[12:0] = 13'h1000;                       // exact tie
                1: v[22:12] = 11'h7ff;                       // rounding carries out
                2: v[22:13] = 10'd0;
                default: ;
            endcase
        end else begin
            case ($urandom_range(5))
                0:       hexp = 5'd0;
                1:       hexp = 5'h1f;
                default: hexp = 5'($urandom_range(31));
            endcase
            v[14:10] = hexp;
            if ($urandom_range(4) == 0) v[9:0] = 10'd0;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT)
            $display("ERROR: %s", msg);
        err_count++;
    endtask

    // Input transfers record their prediction; output transfers check the oldest one.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back('{s_tuser, s_tdata, convert_pattern(s_tuser, s_tdata)});
                if (s_tuser == hfc_pkg::OP_H2F) h2f_sent++;
                else f2h_sent++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %08h with no transfer waiting", m_tdata));
                end else begin
                    oldest = pending_results.pop_front();
                    if (m_tdata !== oldest.result)
                        report_mismatch($sformatf("op %0d operand %08h: result %08h, want %08h",
                                                  oldest.op, oldest.operand, m_tdata,
                                                  oldest.result));
                    else
                        results_ok++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(rx_idle_on && $urandom_range(99) < 25);
        end
    end

    task automatic send_item(input logic op, input logic [31:0] operand);
        @(negedge aclk);
        while (tx_idle_on && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= operand;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        logic op;
        repeat (count) begin
            op = $urandom_range(1) ? hfc_pkg::OP_F2H : hfc_pkg::OP_H2F;
            send_item(op, rand_operand(op));
        end
    endtask

    task automatic test_half_to_float_directed();
        send_item(hfc_pkg::OP_H2F, 32'h0000_0000);   // +0
        send_item(hfc_pkg::OP_H2F, 32'h0000_8000);   // -0
        send_item(hfc_pkg::OP_H2F, 32'h0000_0001);   // smallest subnormal
        send_item(hfc_pkg::OP_H2F, 32'h0000_83ff);   // largest subnormal, negative
        send_item(hfc_pkg::OP_H2F, 32'h0000_0400);   // smallest normal
        send_item(hfc_pkg::OP_H2F, 32'h0000_7bff);   // largest finite
        send_item(hfc_pkg::OP_H2F, 32'h0000_fc00);   // -infinity
        send_item(hfc_pkg::OP_H2F, 32'h0000_7c01);   // NaN with a low payload
        send_item(hfc_pkg::OP_H2F, 32'hffff_3c00);   // upper operand bits must be ignored
        wait_drain();
    endtask

    task automatic test_float_to_half_directed();
        send_item(hfc_pkg::OP_F2H, 32'h8000_0000);   // -0
        send_item(hfc_pkg::OP_F2H, 32'h32ff_ffff);   // just below the subnormal range
        send_item(hfc_pkg::OP_F2H, 32'h3300_0000);   // lowest exponent giving a subnormal
        send_item(hfc_pkg::OP_F2H, 32'h387f_f000);   // top subnormal, rounding carry absorbed
        send_item(hfc_pkg::OP_F2H, 32'h3f80_1000);   // tie rounds up
        send_item(hfc_pkg::OP_F2H, 32'h3f7f_f000);   // mantissa carry raises the exponent
        send_item(hfc_pkg::OP_F2H, 32'h477f_e000);   // largest finite half
        send_item(hfc_pkg::OP_F2H, 32'h477f_f000);   // carry at the top exponent overflows
        send_item(hfc_pkg::OP_F2H, 32'hc780_0000);   // overflow to -infinity
        send_item(hfc_pkg::OP_F2H, 32'h7f80_0000);   // +infinity
        send_item(hfc_pkg::OP_F2H, 32'h7f80_0001);   // NaN whose kept bits are zero
        send_item(hfc_pkg::OP_F2H, 32'hffff_ffff);   // NaN with full payload
        wait_drain();
    endtask

    task automatic test_random_idling();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_random(160);
        wait_drain();
    endtask

    task automatic test_random_no_idling();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random(120);
        wait_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering, so the pipeline fills.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_reqs++;
        send_random(40);
        wait_drain();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pauses();
        repeat (6) begin
            send_random(20);
            wait_drain();
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        test_half_to_float_directed();
        test_float_to_half_directed();
        test_random_idling();
        test_random_no_idling();
        test_backpressure();
        test_sender_pauses();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (DRAIN_LIMIT) begin
            if (pending_results.size() != 0) @(posedge aclk);
        end
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        repeat (10) @(posedge aclk);
        $display("Converted %0d half-to-float and %0d float-to-half operands, %0d matched.",
                 h2f_sent, f2h_sent, results_ok);
        $display("Covered special values, rounding ties and carries, and long output stalls.");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
